// File: sv/four_key_press_and_hold_detector_macros.svh
// Assertion macros for the four-key press and hold detector.
`ifndef FOUR_KEY_PRESS_AND_HOLD_DETECTOR_MACROS_SVH
`define FOUR_KEY_PRESS_AND_HOLD_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FKHD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FKHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/fkhd_pkg.sv
// Shared types and constants for the four-key press and hold detector.
package fkhd_pkg;

   localparam int CNT_W  = 10;
   localparam int CODE_W = 3;
   localparam int PIN_W  = 4;
   localparam int KEYS   = 4;
   localparam int CSR_IDX_W = 2;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_NONE  = 3'd0,
      CODE_ESC   = 3'd1,
      CODE_UP    = 3'd2,
      CODE_DOWN  = 3'd3,
      CODE_ENTER = 3'd4,
      CODE_MENU  = 3'd5,
      CODE_EXIT  = 3'd6,
      CODE_RESET = 3'd7
   } code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MENU_HOLD  = 2'd0,
      CSR_EXIT_HOLD  = 2'd1,
      CSR_RESET_HOLD = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   localparam cnt_type MENU_HOLD_RESET  = 10'd100;
   localparam cnt_type EXIT_HOLD_RESET  = 10'd500;
   localparam cnt_type RESET_HOLD_RESET = 10'd500;

   // Key order: escape, up, down, enter.
   localparam int KEY_ESC   = 0;
   localparam int KEY_UP    = 1;
   localparam int KEY_DOWN  = 2;
   localparam int KEY_ENTER = 3;

   localparam int PIN_ESC   = 0;
   localparam int PIN_UP    = 1;
   localparam int PIN_ENTER = 2;
   localparam int PIN_DOWN  = 3;

   typedef struct packed {
      cnt_type menu_hold;
      cnt_type exit_hold;
      cnt_type reset_hold;
   } cfg_type;

endpackage

// File: sv/four_key_press_and_hold_detector.sv
// Top level of the four-key press and hold detector.
//
//   channel | ports         | direction | content
//   req     | req_*         | in        | pin_levels, one sampling tick
//   rsp     | rsp_*         | out       | key_code, latched_code
//   csr     | csr_*         | in        | hold thresholds, write only
//
// One request a cycle unless rsp stalls; rsp_valid rises once a request has passed
// the input register, then the result register after the key and counter logic.
// Synchronous reset clears key state, counters, locks, latched code and
// restores the default thresholds.
// A stalled rsp holds the result; one further request waits in the input
// register, and req_ready drops only when both registers are full.
`include "four_key_press_and_hold_detector_macros.svh"

module four_key_press_and_hold_detector
   import fkhd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIN_W-1:0]     req_pin_levels,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CODE_W-1:0]    rsp_key_code,
   output logic [CODE_W-1:0]    rsp_latched_code,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   logic             in_valid_ff, in_valid_in;
   logic [PIN_W-1:0] pins_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   code_type         key_code_ff, latched_ff;

   logic     advance;
   logic     step;
   logic     req_take;
   cfg_type  cfg;
   code_type key_code;
   code_type latched_code;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign step      = in_valid_ff && advance;

   always_comb begin
      priority if (req_take) in_valid_in = 1'b1;
      else if (advance)      in_valid_in = 1'b0;
      else                   in_valid_in = in_valid_ff;

      priority if (step)     rsp_valid_in = 1'b1;
      else if (rsp_ready)    rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   fkhd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fkhd_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .pins         (pins_ff),
      .cfg          (cfg),
      .key_code     (key_code),
      .latched_code (latched_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pins_ff <= req_pin_levels;
      end
      if (step) begin
         key_code_ff <= key_code;
         latched_ff  <= latched_code;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_code     = key_code_ff;
   assign rsp_latched_code = latched_ff;

   `FKHD_ASSERT_NOW(a_latch_follows_code, clock, reset,
      rsp_valid && (key_code_ff != CODE_NONE), latched_ff == key_code_ff,
      "latched code differs from nonzero key code")
   `FKHD_ASSERT_NEXT(a_step_gives_rsp, clock, reset,
      step, rsp_valid_ff,
      "processed request did not reach the result register")
   `FKHD_ASSERT_NOW(a_full_blocks_req, clock, reset,
      in_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready,
      "request taken while both stages are full")

endmodule

// File: sv/fkhd_csr.sv
// Hold threshold registers written through the csr port.
module fkhd_csr
   import fkhd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MENU_HOLD:  cfg_in.menu_hold  = csr_wdata;
            CSR_EXIT_HOLD:  cfg_in.exit_hold  = csr_wdata;
            CSR_RESET_HOLD: cfg_in.reset_hold = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.menu_hold  <= MENU_HOLD_RESET;
         cfg_ff.exit_hold  <= EXIT_HOLD_RESET;
         cfg_ff.reset_hold <= RESET_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/fkhd_engine.sv
// Key state, hold counters and code selection for one sampling tick.
module fkhd_engine
   import fkhd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [PIN_W-1:0] pins,
   input  cfg_type          cfg,
   output code_type         key_code,
   output code_type         latched_code
);

   logic [KEYS-1:0] pressed_ff, pressed_in;
   cnt_type         esc_cnt_ff, esc_cnt_in;
   logic            esc_lock_ff, esc_lock_in;
   cnt_type         up_cnt_ff, up_cnt_in;
   logic            up_lock_ff, up_lock_in;
   code_type        last_ff, last_in;

   logic [KEYS-1:0] down;
   logic [KEYS-1:0] fresh;
   code_type        code;

   always_comb begin
      down[KEY_ESC]   = ~pins[PIN_ESC];
      down[KEY_UP]    = ~pins[PIN_UP];
      down[KEY_DOWN]  = ~pins[PIN_DOWN];
      down[KEY_ENTER] = ~pins[PIN_ENTER];
      fresh      = down & ~pressed_ff;
      pressed_in = down;

      // higher key index wins
      priority if (fresh[KEY_ENTER]) code = CODE_ENTER;
      else if (fresh[KEY_DOWN])      code = CODE_DOWN;
      else if (fresh[KEY_UP])        code = CODE_UP;
      else if (fresh[KEY_ESC])       code = CODE_ESC;
      else                           code = CODE_NONE;

      esc_cnt_in  = esc_cnt_ff;
      esc_lock_in = esc_lock_ff;
      if (!down[KEY_ESC]) begin
         esc_cnt_in  = '0;
         esc_lock_in = 1'b0;
      end else if (!esc_lock_ff) begin
         esc_cnt_in = esc_cnt_ff + cnt_type'(1);
         if (esc_cnt_in == cfg.menu_hold) code = CODE_MENU;
         if (esc_cnt_in == cfg.exit_hold) begin
            esc_lock_in = 1'b1;
            code        = CODE_EXIT;
         end
      end

      up_cnt_in  = up_cnt_ff;
      up_lock_in = up_lock_ff;
      if (!down[KEY_UP]) begin
         up_cnt_in  = '0;
         up_lock_in = 1'b0;
      end else if (!up_lock_ff) begin
         up_cnt_in = up_cnt_ff + cnt_type'(1);
         if (up_cnt_in == cfg.reset_hold) begin
            up_lock_in = 1'b1;
            code       = CODE_RESET;
         end
      end

      last_in = (code != CODE_NONE) ? code : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff  <= '0;
         esc_cnt_ff  <= '0;
         esc_lock_ff <= 1'b0;
         up_cnt_ff   <= '0;
         up_lock_ff  <= 1'b0;
         last_ff     <= CODE_NONE;
      end else if (step) begin
         pressed_ff  <= pressed_in;
         esc_cnt_ff  <= esc_cnt_in;
         esc_lock_ff <= esc_lock_in;
         up_cnt_ff   <= up_cnt_in;
         up_lock_ff  <= up_lock_in;
         last_ff     <= last_in;
      end
   end

   assign key_code     = code;
   assign latched_code = last_in;

endmodule

// File: test/four_key_press_and_hold_detector_test.sv
// Self-checking testbench for the four-key press and hold detector.
`timescale 1ns / 1ps

module four_key_press_and_hold_detector_test;
   import fkhd_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      code_type key;
      code_type latched;
   } tick_codes_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIN_W-1:0]     req_pin_levels = '1;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CODE_W-1:0]    rsp_key_code;
   logic [CODE_W-1:0]    rsp_latched_code;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MENU_HOLD;
   logic [CNT_W-1:0]     csr_wdata = '0;

   // predictor state
   cfg_type         hold_cfg = '{MENU_HOLD_RESET, EXIT_HOLD_RESET, RESET_HOLD_RESET};
   logic [KEYS-1:0] keys_held = '0;
   cnt_type         esc_count = '0;
   logic            esc_lock = 1'b0;
   cnt_type         up_count = '0;
   logic            up_lock = 1'b0;
   code_type        last_code_seen = CODE_NONE;

   tick_codes_type  expected_codes[$];
   tick_codes_type  oldest;
   int              fail_count = 0;
   int              quiet_cycles = 0;
   int              rsp_hold = 0;
   int              rsp_stall;
   bit              idle_on = 1'b1;

   four_key_press_and_hold_detector u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pin_levels   (req_pin_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_code     (rsp_key_code),
      .rsp_latched_code (rsp_latched_code),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic predict_tick_codes(input logic [PIN_W-1:0] pins);
      logic [KEYS-1:0] pressed_now;
      code_type        code;
      code = CODE_NONE;
      pressed_now[KEY_ESC]   = !pins[PIN_ESC];
      pressed_now[KEY_UP]    = !pins[PIN_UP];
      pressed_now[KEY_DOWN]  = !pins[PIN_DOWN];
      pressed_now[KEY_ENTER] = !pins[PIN_ENTER];
      for (int k = 0; k < KEYS; k++) begin
         if (pressed_now[k]) begin
            if (!keys_held[k]) begin
               keys_held[k] = 1'b1;
               case (k)
                  KEY_ESC: code = CODE_ESC;
                  KEY_UP: code = CODE_UP;
                  KEY_DOWN: code = CODE_DOWN;
                  default: code = CODE_ENTER;
               endcase
            end
         end else begin
            keys_held[k] = 1'b0;
         end
      end
      if (pressed_now[KEY_ESC]) begin
         if (!esc_lock) begin
            esc_count = esc_count + cnt_type'(1);
            if (esc_count == hold_cfg.menu_hold) code = CODE_MENU;
            if (esc_count == hold_cfg.exit_hold) begin
               esc_lock = 1'b1;
               code = CODE_EXIT;
            end
         end
      end else begin
         esc_lock = 1'b0;
         esc_count = '0;
      end
      // up hold is applied last
      if (pressed_now[KEY_UP]) begin
         if (!up_lock) begin
            up_count = up_count + cnt_type'(1);
            if (up_count == hold_cfg.reset_hold) begin
               up_lock = 1'b1;
               code = CODE_RESET;
            end
         end
      end else begin
         up_lock = 1'b0;
         up_count = '0;
      end
      if (code != CODE_NONE) last_code_seen = code;
      expected_codes.push_back('{code, last_code_seen});
   endtask

   task automatic send_tick(input logic [PIN_W-1:0] pins);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pin_levels <= pins;
      do @(posedge clock); while (!req_ready);
      predict_tick_codes(pins);
   endtask

   task automatic hold_pins(input logic [PIN_W-1:0] pins, input int ticks);
      repeat (ticks) send_tick(pins);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input cnt_type value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MENU_HOLD: hold_cfg.menu_hold = value;
         CSR_EXIT_HOLD: hold_cfg.exit_hold = value;
         CSR_RESET_HOLD: hold_cfg.reset_hold = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_holds(input cnt_type menu, input cnt_type exit_ticks,
                              input cnt_type up_ticks);
      wait_for_results();
      write_csr(CSR_MENU_HOLD, menu);
      write_csr(CSR_EXIT_HOLD, exit_ticks);
      write_csr(CSR_RESET_HOLD, up_ticks);
   endtask

   // escape and up held together past the default thresholds
   task automatic test_default_thresholds();
      hold_pins(4'hC, 502);
      send_tick(4'hF);
   endtask

   task automatic test_short_codes();
      write_holds(10'd2, 10'd4, 10'd3);
      send_tick(4'hF);
      send_tick(4'hE);
      send_tick(4'hF);
      send_tick(4'hD);
      send_tick(4'hF);
      send_tick(4'hB);
      send_tick(4'hF);
      send_tick(4'h7);
      send_tick(4'hF);
      hold_pins(4'h0, 5);
      send_tick(4'hF);
      hold_pins(4'hD, 4);
      send_tick(4'hF);
   endtask

   task automatic test_equal_thresholds();
      write_holds(10'd3, 10'd3, 10'd10);
      hold_pins(4'hE, 5);
      send_tick(4'hF);
   endtask

   task automatic test_exit_below_menu();
      write_holds(10'd6, 10'd3, 10'd5);
      hold_pins(4'hE, 8);
      send_tick(4'hF);
      hold_pins(4'hE, 4);
      send_tick(4'hF);
   endtask

   task automatic test_unused_index();
      write_holds(10'd4, 10'd7, 10'd3);
      write_csr(CSR_UNUSED, 10'd1);
      hold_pins(4'hD, 4);
      hold_pins(4'hE, 8);
      send_tick(4'hF);
   endtask

   task automatic test_counter_wrap();
      // zero thresholds only match when the counters wrap
      write_holds(10'd1023, 10'd0, 10'd0);
      hold_pins(4'hC, 1026);
      send_tick(4'hF);
   endtask

   task automatic test_random_holds();
      logic [PIN_W-1:0] pins;
      logic [PIN_W-1:0] tick_pins;
      int               sent;
      int               len;
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 0)
            write_holds(10'd1, 10'd1, 10'd1);
         else
            write_holds(cnt_type'($urandom_range(1, 12)), cnt_type'($urandom_range(1, 12)),
                        cnt_type'($urandom_range(1, 12)));
         idle_on = (phase % 3) != 2;
         sent = 0;
         while (sent < 40) begin
            if ($urandom_range(0, 9) < 7) begin
               pins = PIN_W'($urandom_range(0, 15));
               pins[$urandom_range(0, 1)] = 1'b0;
               len = $urandom_range(1, 16);
               for (int i = 0; i < len; i++) begin
                  tick_pins = pins;
                  if ($urandom_range(0, 7) == 0)
                     tick_pins[$urandom_range(0, 3)] = !tick_pins[$urandom_range(0, 3)];
                  send_tick(tick_pins);
               end
               sent += len;
               if ($urandom_range(0, 1) == 0) begin
                  send_tick(4'hF);
                  sent++;
               end
            end else begin
               send_tick(PIN_W'($urandom_range(0, 15)));
               sent++;
            end
            if ($urandom_range(0, 39) == 0) wait_for_results();
         end
      end
      idle_on = 1'b1;
   endtask

   // result side: random stall after each accepted result
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else if (rsp_valid && rsp_ready) begin
         rsp_stall = idle_on ? $urandom_range(0, 5) : 0;
         rsp_hold <= rsp_stall;
         rsp_ready <= (rsp_stall == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_codes.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected result: key %0d latched %0d",
                        rsp_key_code, rsp_latched_code);
         end else begin
            oldest = expected_codes.pop_front();
            if (rsp_key_code !== oldest.key || rsp_latched_code !== oldest.latched) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("mismatch: expected key %0d latched %0d, got key %0d latched %0d",
                           oldest.key, oldest.latched, rsp_key_code, rsp_latched_code);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_thresholds();
      test_short_codes();
      test_equal_thresholds();
      test_exit_below_menu();
      test_unused_index();
      test_counter_wrap();
      test_random_holds();
      wait_for_results();
      if (fail_count == 0 && expected_codes.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
